[sv/rrts_pkg.sv]
// rrts_pkg: shared sizes, codes and controller/datapath types for the
// round-robin task scheduler. No dependencies.
package rrts_pkg;

   localparam int TASKS      = 16;
   localparam int SIG_DEPTH  = 16;

   localparam int TASK_W     = $clog2(TASKS);
   localparam int PTR_W      = $clog2(SIG_DEPTH);
   localparam int ITER_W     = $clog2(TASKS + 1);
   localparam int RING_DEPTH = TASKS * SIG_DEPTH;
   localparam int RING_AW    = $clog2(RING_DEPTH);

   // fixed field widths
   localparam int SIG_W        = 5;
   localparam int FIELD_TASK_W = 4;
   localparam int STATUS_W     = 3;
   localparam int OP_W         = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 32;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FATAL_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTINUE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP       = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FATAL_MASK_RESET = 32'd2951938046;
   localparam logic [SIG_W-1:0]      CONTINUE_RESET   = 5'd18;
   localparam logic [SIG_W-1:0]      STOP_RESET       = 5'd19;

   typedef logic [TASK_W-1:0]       task_idx_type;
   typedef logic [PTR_W-1:0]        ptr_type;
   typedef logic [ITER_W-1:0]       iter_type;
   typedef logic [RING_AW-1:0]      ring_addr_type;
   typedef logic [SIG_W-1:0]        sig_type;
   typedef logic [FIELD_TASK_W-1:0] field_task_type;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_POST   = 2'd1,
      OP_SWITCH = 2'd2,
      OP_START  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_SLOT  = 3'd1,
      ST_DROPPED  = 3'd2,
      ST_KILLED0  = 3'd3,
      ST_NONE_RUN = 3'd4,
      ST_DEAD0    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_REPLY_HALT,
      CMD_POST,
      CMD_START,
      CMD_CREATE_INIT,
      CMD_CREATE_TAKE,
      CMD_CREATE_NEXT,
      CMD_CREATE_FAIL,
      CMD_SWITCH_INIT,
      CMD_RING_READ,
      CMD_RING_APPLY,
      CMD_SCAN_STEP,
      CMD_NONE_RUN,
      CMD_PUSH
   } cmd_type;

   typedef struct packed {
      logic   halted;
      op_type op;
      logic   cur_alive;
      logic   cur_paused;
      logic   cur_pending;
      logic   cur_last;
      logic   scan_done;
      logic   rsp_busy;
   } dp_status_type;

endpackage

[sv/rrts_ram.sv]
// rrts_ram: generic simple dual-port RAM, one write port, one registered
// read port. No dependencies.
module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rrts_ctrl.sv]
// rrts_ctrl: sequencer for the scheduler; steps create scans, queue drains
// and the round-robin search. Depends on rrts_pkg.
module rrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rrts_pkg::dp_status_type dp_status,
   output rrts_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CREATE,
      S_DRAIN,
      S_APPLY,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      scan_mode_ff, scan_mode_in;

   always_comb begin
      state_in     = state_ff;
      scan_mode_in = scan_mode_ff;
      cmd          = rrts_pkg::CMD_IDLE;
      req_tready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = rrts_pkg::CMD_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (dp_status.halted) begin
               cmd      = rrts_pkg::CMD_REPLY_HALT;
               state_in = S_FINISH;
            end else begin
               case (dp_status.op)
                  rrts_pkg::OP_CREATE: begin
                     cmd      = rrts_pkg::CMD_CREATE_INIT;
                     state_in = S_CREATE;
                  end
                  rrts_pkg::OP_POST: begin
                     cmd      = rrts_pkg::CMD_POST;
                     state_in = S_FINISH;
                  end
                  rrts_pkg::OP_SWITCH: begin
                     cmd          = rrts_pkg::CMD_SWITCH_INIT;
                     scan_mode_in = 1'b0;
                     state_in     = S_DRAIN;
                  end
                  default: begin
                     cmd      = rrts_pkg::CMD_START;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_CREATE: begin
            if (!dp_status.cur_alive) begin
               cmd      = rrts_pkg::CMD_CREATE_TAKE;
               state_in = S_FINISH;
            end else if (dp_status.cur_last) begin
               cmd      = rrts_pkg::CMD_CREATE_FAIL;
               state_in = S_FINISH;
            end else begin
               cmd = rrts_pkg::CMD_CREATE_NEXT;
            end
         end
         S_DRAIN: begin
            if (dp_status.halted) begin
               cmd      = rrts_pkg::CMD_REPLY_HALT;
               state_in = S_FINISH;
            end else if (dp_status.cur_pending && dp_status.cur_alive) begin
               cmd      = rrts_pkg::CMD_RING_READ;
               state_in = S_APPLY;
            end else if (!scan_mode_ff) begin
               // running task drained, start the round-robin search
               cmd          = rrts_pkg::CMD_SCAN_STEP;
               scan_mode_in = 1'b1;
               state_in     = S_SCAN;
            end else if (dp_status.scan_done) begin
               cmd      = rrts_pkg::CMD_NONE_RUN;
               state_in = S_FINISH;
            end else begin
               cmd      = rrts_pkg::CMD_SCAN_STEP;
               state_in = S_SCAN;
            end
         end
         S_APPLY: begin
            cmd      = rrts_pkg::CMD_RING_APPLY;
            state_in = S_DRAIN;
         end
         S_SCAN: begin
            if (dp_status.cur_alive && !dp_status.cur_paused) begin
               cmd      = rrts_pkg::CMD_REPLY_HALT;
               state_in = S_FINISH;
            end else if (dp_status.cur_alive) begin
               // paused task passed over gets its queue drained
               state_in = S_DRAIN;
            end else if (dp_status.scan_done) begin
               cmd      = rrts_pkg::CMD_NONE_RUN;
               state_in = S_FINISH;
            end else begin
               cmd = rrts_pkg::CMD_SCAN_STEP;
            end
         end
         S_FINISH: begin
            if (!dp_status.rsp_busy) begin
               cmd      = rrts_pkg::CMD_PUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_mode_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_mode_ff <= scan_mode_in;
      end
   end

endmodule

[sv/rrts_datapath.sv]
// rrts_datapath: task table, ring pointers, signal ring memory, config
// registers and result register. Depends on rrts_pkg and rrts_ram.
module rrts_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rrts_pkg::cmd_type                   cmd,
   output rrts_pkg::dp_status_type             dp_status,
   input  logic [rrts_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [rrts_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   input  logic [rrts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrts_pkg::CSR_DATA_W-1:0]     csr_data
);

   // config registers
   logic [rrts_pkg::CSR_DATA_W-1:0] fatal_mask_ff;
   rrts_pkg::sig_type               cont_sig_ff;
   rrts_pkg::sig_type               stop_sig_ff;

   // task table
   logic [rrts_pkg::TASKS-1:0] alive_ff, alive_in;
   logic [rrts_pkg::TASKS-1:0] paused_ff, paused_in;
   rrts_pkg::ptr_type          rd_ptr_ff [rrts_pkg::TASKS];
   rrts_pkg::ptr_type          rd_ptr_in [rrts_pkg::TASKS];
   rrts_pkg::ptr_type          wr_ptr_ff [rrts_pkg::TASKS];
   rrts_pkg::ptr_type          wr_ptr_in [rrts_pkg::TASKS];
   rrts_pkg::ptr_type          count_ff  [rrts_pkg::TASKS];
   rrts_pkg::ptr_type          count_in  [rrts_pkg::TASKS];
   rrts_pkg::task_idx_type     running_ff, running_in;
   rrts_pkg::status_type       halt_ff, halt_in;

   // request and walk registers
   rrts_pkg::op_type           op_ff, op_in;
   logic [3:0]                 target_ff, target_in;
   rrts_pkg::sig_type          sig_ff, sig_in;
   rrts_pkg::task_idx_type     cursor_ff, cursor_in;
   rrts_pkg::iter_type         iter_ff, iter_in;

   // result and response registers
   rrts_pkg::task_idx_type     res_task_ff, res_task_in;
   rrts_pkg::status_type       res_status_ff, res_status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rrts_pkg::field_task_type   rsp_task_ff, rsp_task_in;
   rrts_pkg::status_type       rsp_status_ff, rsp_status_in;

   // ring memory ports
   logic                       ring_we;
   rrts_pkg::ring_addr_type    ring_waddr;
   rrts_pkg::ring_addr_type    ring_raddr;
   logic                       ring_re;
   rrts_pkg::sig_type          ring_q;

   rrts_pkg::task_idx_type     tgt_idx;
   logic                       tgt_ok;
   rrts_pkg::task_idx_type     cursor_next;

   assign tgt_idx     = rrts_pkg::task_idx_type'(target_ff);
   assign tgt_ok      = (32'(target_ff) < 32'(rrts_pkg::TASKS));
   assign cursor_next = (cursor_ff == rrts_pkg::task_idx_type'(rrts_pkg::TASKS - 1))
                        ? '0 : cursor_ff + rrts_pkg::task_idx_type'(1);

   assign ring_waddr = rrts_pkg::ring_addr_type'(int'(tgt_idx) * rrts_pkg::SIG_DEPTH
                                                 + int'(wr_ptr_ff[tgt_idx]));
   assign ring_raddr = rrts_pkg::ring_addr_type'(int'(cursor_ff) * rrts_pkg::SIG_DEPTH
                                                 + int'(rd_ptr_ff[cursor_ff]));
   assign ring_re    = (cmd == rrts_pkg::CMD_RING_READ);

   function automatic rrts_pkg::ptr_type ptr_inc(input rrts_pkg::ptr_type p);
      return (p == rrts_pkg::ptr_type'(rrts_pkg::SIG_DEPTH - 1))
             ? '0 : p + rrts_pkg::ptr_type'(1);
   endfunction

   always_comb begin
      alive_in      = alive_ff;
      paused_in     = paused_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      count_in      = count_ff;
      running_in    = running_ff;
      halt_in       = halt_ff;
      op_in         = op_ff;
      target_in     = target_ff;
      sig_in        = sig_ff;
      cursor_in     = cursor_ff;
      iter_in       = iter_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_task_in   = rsp_task_ff;
      rsp_status_in = rsp_status_ff;
      ring_we       = 1'b0;
      case (cmd)
         rrts_pkg::CMD_LOAD: begin
            op_in         = rrts_pkg::op_type'(req_tuser);
            target_in     = req_tdata[3:0];
            sig_in        = req_tdata[8:4];
            res_task_in   = '0;
            res_status_in = rrts_pkg::ST_OK;
         end
         rrts_pkg::CMD_REPLY_HALT: begin
            res_task_in   = running_ff;
            res_status_in = halt_ff;
         end
         rrts_pkg::CMD_POST: begin
            if (!tgt_ok ||
                count_ff[tgt_idx] >= rrts_pkg::ptr_type'(rrts_pkg::SIG_DEPTH - 1)) begin
               res_status_in = rrts_pkg::ST_DROPPED;
            end else begin
               ring_we            = 1'b1;
               wr_ptr_in[tgt_idx] = ptr_inc(wr_ptr_ff[tgt_idx]);
               count_in[tgt_idx]  = count_ff[tgt_idx] + rrts_pkg::ptr_type'(1);
            end
         end
         rrts_pkg::CMD_START: begin
            running_in  = '0;
            res_task_in = '0;
            if (!alive_ff[0]) begin
               halt_in       = rrts_pkg::ST_DEAD0;
               res_status_in = rrts_pkg::ST_DEAD0;
            end
         end
         rrts_pkg::CMD_CREATE_INIT: begin
            cursor_in = '0;
         end
         rrts_pkg::CMD_CREATE_TAKE: begin
            alive_in[cursor_ff]  = 1'b1;
            paused_in[cursor_ff] = 1'b0;
            rd_ptr_in[cursor_ff] = '0;
            wr_ptr_in[cursor_ff] = '0;
            count_in[cursor_ff]  = '0;
            res_task_in          = cursor_ff;
         end
         rrts_pkg::CMD_CREATE_NEXT: begin
            cursor_in = cursor_next;
         end
         rrts_pkg::CMD_CREATE_FAIL: begin
            res_status_in = rrts_pkg::ST_NO_SLOT;
         end
         rrts_pkg::CMD_SWITCH_INIT: begin
            cursor_in = running_ff;
            iter_in   = '0;
         end
         rrts_pkg::CMD_RING_APPLY: begin
            count_in[cursor_ff] = count_ff[cursor_ff] - rrts_pkg::ptr_type'(1);
            rd_ptr_in[cursor_ff] = ptr_inc(rd_ptr_ff[cursor_ff]);
            if (ring_q == cont_sig_ff) begin
               paused_in[cursor_ff] = 1'b0;
            end else if (ring_q == stop_sig_ff) begin
               paused_in[cursor_ff] = 1'b1;
            end else if (fatal_mask_ff[ring_q]) begin
               if (cursor_ff == '0) begin
                  // slot 0 killed: halt, read pointer stays put
                  halt_in              = rrts_pkg::ST_KILLED0;
                  rd_ptr_in[cursor_ff] = rd_ptr_ff[cursor_ff];
               end else begin
                  alive_in[cursor_ff] = 1'b0;
               end
            end
         end
         rrts_pkg::CMD_SCAN_STEP: begin
            cursor_in  = cursor_next;
            running_in = cursor_next;
            iter_in    = iter_ff + rrts_pkg::iter_type'(1);
         end
         rrts_pkg::CMD_NONE_RUN: begin
            halt_in       = rrts_pkg::ST_NONE_RUN;
            res_task_in   = running_ff;
            res_status_in = rrts_pkg::ST_NONE_RUN;
         end
         rrts_pkg::CMD_PUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_task_in   = rrts_pkg::field_task_type'(res_task_ff);
            rsp_status_in = res_status_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fatal_mask_ff <= rrts_pkg::FATAL_MASK_RESET;
         cont_sig_ff   <= rrts_pkg::CONTINUE_RESET;
         stop_sig_ff   <= rrts_pkg::STOP_RESET;
         alive_ff      <= '0;
         paused_ff     <= '0;
         rd_ptr_ff     <= '{default: '0};
         wr_ptr_ff     <= '{default: '0};
         count_ff      <= '{default: '0};
         running_ff    <= '0;
         halt_ff       <= rrts_pkg::ST_OK;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rrts_pkg::CSR_FATAL_MASK: fatal_mask_ff <= csr_data;
               rrts_pkg::CSR_CONTINUE:   cont_sig_ff   <= csr_data[rrts_pkg::SIG_W-1:0];
               rrts_pkg::CSR_STOP:       stop_sig_ff   <= csr_data[rrts_pkg::SIG_W-1:0];
               default: begin
               end
            endcase
         end
         alive_ff     <= alive_in;
         paused_ff    <= paused_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         halt_ff      <= halt_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      target_ff     <= target_in;
      sig_ff        <= sig_in;
      iter_ff       <= iter_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_status_ff <= rsp_status_in;
   end

   rrts_ram #(
      .WIDTH(rrts_pkg::SIG_W),
      .DEPTH(rrts_pkg::RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_we),
      .wr_addr(ring_waddr),
      .wr_data(sig_ff),
      .rd_en  (ring_re),
      .rd_addr(ring_raddr),
      .rd_data(ring_q)
   );

   always_comb begin
      dp_status.halted      = (halt_ff != rrts_pkg::ST_OK);
      dp_status.op          = op_ff;
      dp_status.cur_alive   = alive_ff[cursor_ff];
      dp_status.cur_paused  = paused_ff[cursor_ff];
      dp_status.cur_pending = (count_ff[cursor_ff] != '0);
      dp_status.cur_last    = (cursor_ff == rrts_pkg::task_idx_type'(rrts_pkg::TASKS - 1));
      dp_status.scan_done   = (iter_ff == rrts_pkg::iter_type'(rrts_pkg::TASKS));
      dp_status.rsp_busy    = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_status_ff, rsp_task_ff};

   // a halt code only goes away through reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (halt_ff != rrts_pkg::ST_OK) |=> (halt_ff == $past(halt_ff)))
      else $error("halt code changed while halted");

   a_running_range: assert property (@(posedge clock) disable iff (reset)
      32'(running_ff) < 32'(rrts_pkg::TASKS))
      else $error("running task out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[cursor_ff] <= rrts_pkg::ptr_type'(rrts_pkg::SIG_DEPTH - 1))
      else $error("signal queue overfilled");

   // a drained signal must come from a live task with something queued
   a_apply_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd == rrts_pkg::CMD_RING_APPLY) |-> (alive_ff[cursor_ff] && count_ff[cursor_ff] != '0))
      else $error("drain step on empty or dead slot");

endmodule

[sv/round_robin_task_scheduler_signals_core.sv]
// round_robin_task_scheduler_signals_core: top level of the task scheduler.
// Depends on rrts_pkg, rrts_ctrl, rrts_datapath (which holds rrts_ram).
//
//   group  direction  payload
//   req    in         tuser: op; tdata: target_task, signal_number
//   rsp    out        tdata: result_task, status
//   csr    in         csr_index, csr_data (write only)
//
// a request goes from decode to a finish state: post and start directly,
// create after stepping to the first free slot or the last one, halted
// replies directly; a switch drains the running slot, each queued signal a
// ring read and then an apply as the read port is registered, then walks the
// slots round-robin and drains each paused slot that it passes over.
// reset synchronously clears the task table, pointers and halt code and reloads the config registers.
// a result waiting on rsp_tready holds the next request in its finish state.
module round_robin_task_scheduler_signals_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrts_pkg::REQ_DATA_W-1:0]     req_tdata,  // target_task[3:0], signal_number[8:4]
   input  logic [rrts_pkg::OP_W-1:0]           req_tuser,  // op[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // result_task[3:0], status[6:4]
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rrts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrts_pkg::CSR_DATA_W-1:0]     csr_data
);

   rrts_pkg::cmd_type       cmd;
   rrts_pkg::dp_status_type dp_status;

   assign csr_ready = 1'b1;

   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   rrts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .dp_status (dp_status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule
